// ===== rtl/lgs_pkg.sv =====
`timescale 1ns / 1ps

package lgs_pkg;

    // default grid size
    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    // fixed field widths
    localparam int REQ_W   = 2;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int ALIVE_W = 13;
    localparam int GEN_W   = 32;

    // live count saturates here
    localparam int ALIVE_MAX = 8191;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    // memory port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_data;
    } t_mem_ctl;

endpackage

// ===== rtl/lgs_mem.sv =====
`timescale 1ns / 1ps

module lgs_mem #(
    parameter int AW = 13
) (
    input  logic              i_clk,
    input  lgs_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [AW-1:0]     i_rd_addr,
    output logic              o_rd_data
);

    logic r_mem [2**AW];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lgs_step_engine.sv =====
`timescale 1ns / 1ps

module lgs_step_engine #(
    parameter int GRID_ROWS = lgs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lgs_pkg::GRID_COLS_DEF,
    localparam int ROW_AW = $clog2(GRID_ROWS),
    localparam int COL_AW = $clog2(GRID_COLS),
    localparam int AW     = ROW_AW + COL_AW,
    localparam int CELLS  = GRID_ROWS * GRID_COLS,
    localparam int TW     = $clog2(CELLS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_rd_data,
    output lgs_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_rd_addr,
    output logic [AW-1:0]     o_wr_addr,
    output logic              o_done,
    output logic [TW-1:0]     o_total
);

    // reads run one row plus one cell ahead of the evaluated cell
    localparam int ISSUES = CELLS + GRID_COLS + 1;
    localparam int IW     = $clog2(ISSUES + 1);
    localparam int SRL    = 2 * GRID_COLS + 3;

    // window taps, newest cell at tap 0
    localparam int T_SE = 0;
    localparam int T_S  = 1;
    localparam int T_SW = 2;
    localparam int T_E  = GRID_COLS;
    localparam int T_C  = GRID_COLS + 1;
    localparam int T_W  = GRID_COLS + 2;
    localparam int T_NE = 2 * GRID_COLS;
    localparam int T_N  = 2 * GRID_COLS + 1;
    localparam int T_NW = 2 * GRID_COLS + 2;

    logic              r_run;
    logic [IW-1:0]     r_icnt;
    logic [ROW_AW-1:0] r_ir;
    logic [COL_AW-1:0] r_ic;
    logic              r_s1_vld;
    logic              r_s1_real;
    logic              r_s1_ev;
    logic [SRL-1:0]    r_sr;
    logic              r_s2_vld;
    logic [ROW_AW-1:0] r_pr;
    logic [COL_AW-1:0] r_pc;
    logic [TW-1:0]     r_total;
    logic              r_done;

    logic       rd_real;
    logic       at_top;
    logic       at_bot;
    logic       at_lft;
    logic       at_rgt;
    logic       last_cell;
    logic [3:0] nbr_sum;
    logic       next_cell;

    assign rd_real = r_run && (r_icnt < IW'(CELLS));

    assign at_top    = (r_pr == '0);
    assign at_bot    = (r_pr == ROW_AW'(GRID_ROWS - 1));
    assign at_lft    = (r_pc == '0);
    assign at_rgt    = (r_pc == COL_AW'(GRID_COLS - 1));
    assign last_cell = at_bot && at_rgt;

    // no wrap: taps across an edge count as dead
    always_comb begin
        nbr_sum = 4'(r_sr[T_SE] & ~at_bot & ~at_rgt)
                + 4'(r_sr[T_S]  & ~at_bot)
                + 4'(r_sr[T_SW] & ~at_bot & ~at_lft)
                + 4'(r_sr[T_E]  & ~at_rgt)
                + 4'(r_sr[T_W]  & ~at_lft)
                + 4'(r_sr[T_NE] & ~at_top & ~at_rgt)
                + 4'(r_sr[T_N]  & ~at_top)
                + 4'(r_sr[T_NW] & ~at_top & ~at_lft);
        next_cell = (nbr_sum == 4'd3) || (r_sr[T_C] && (nbr_sum == 4'd2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_icnt    <= '0;
            r_ir      <= '0;
            r_ic      <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_real <= 1'b0;
            r_s1_ev   <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_pr      <= '0;
            r_pc      <= '0;
            r_total   <= '0;
            r_done    <= 1'b0;
        end else if (i_start) begin
            r_run    <= 1'b1;
            r_icnt   <= '0;
            r_ir     <= '0;
            r_ic     <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_pr     <= '0;
            r_pc     <= '0;
            r_total  <= '0;
            r_done   <= 1'b0;
        end else begin
            // read issue
            r_s1_vld  <= r_run;
            r_s1_real <= rd_real;
            r_s1_ev   <= (r_icnt >= IW'(GRID_COLS + 1));
            if (r_run) begin
                r_icnt <= r_icnt + 1'b1;
                if (r_icnt == IW'(ISSUES - 1)) begin
                    r_run <= 1'b0;
                end
            end
            if (rd_real) begin
                if (r_ic == COL_AW'(GRID_COLS - 1)) begin
                    r_ic <= '0;
                    r_ir <= r_ir + 1'b1;
                end else begin
                    r_ic <= r_ic + 1'b1;
                end
            end
            // evaluate and write back
            r_s2_vld <= r_s1_vld && r_s1_ev;
            if (r_s2_vld) begin
                r_total <= r_total + TW'(next_cell);
                if (at_rgt) begin
                    r_pc <= '0;
                    r_pr <= r_pr + 1'b1;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end
            r_done <= r_s2_vld && last_cell;
        end
    end

    // window over the last two rows plus three cells
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_sr <= {r_sr[SRL-2:0], r_s1_real & i_rd_data};
        end
    end

    assign o_mem_ctl.rd_en   = rd_real;
    assign o_mem_ctl.wr_en   = r_s2_vld;
    assign o_mem_ctl.wr_data = next_cell;
    assign o_rd_addr         = {r_ir, r_ic};
    assign o_wr_addr         = {r_pr, r_pc};
    assign o_done            = r_done;
    assign o_total           = r_total;

endmodule

// ===== rtl/life_generation_step.sv =====
`timescale 1ns / 1ps

// Game of life grid (rule B3/S23, edges dead, no wrap) of GRID_ROWS x GRID_COLS
// one-bit cells held in a synchronous memory with two banks: the live grid and
// the next generation, swapped at the end of each step instead of copied. One
// input word is taken at a time and gives exactly one output word carrying the
// cell value (reads only) and the current statistics. During an advance the scan
// reads one cell per cycle through the single memory read port and writes the
// new value into the other bank one row plus one cell behind. After reset the
// live bank is cleared one entry per cycle, with o_in_stall high. A cell address
// outside the grid makes a write do nothing and a read return 0; request code 3
// does nothing. A finished word waits in the output register while the next
// input word is taken.

module life_generation_step #(
    parameter int GRID_ROWS = lgs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lgs_pkg::GRID_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lgs_pkg::REQ_W-1:0]   i_req_type,
    input  logic [lgs_pkg::ROW_W-1:0]   i_row,
    input  logic [lgs_pkg::COL_W-1:0]   i_col,
    input  logic                        i_cell_in,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_cell_out,
    output logic [lgs_pkg::ALIVE_W-1:0] o_alive_count,
    output logic [lgs_pkg::GEN_W-1:0]   o_generation_count,
    output logic                        o_grid_full
);

    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int COL_AW = $clog2(GRID_COLS);
    localparam int AW     = ROW_AW + COL_AW;
    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int TW     = $clog2(CELLS + 1);
    localparam int SW     = (TW > lgs_pkg::ALIVE_W) ? TW : lgs_pkg::ALIVE_W;
    localparam logic [lgs_pkg::ALIVE_W-1:0] FULL_ALIVE =
        lgs_pkg::ALIVE_W'((CELLS > lgs_pkg::ALIVE_MAX) ? lgs_pkg::ALIVE_MAX : CELLS);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_STEP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                        r_bank;        // bank holding the live grid
    logic [AW-1:0]               r_clr_addr;
    logic [lgs_pkg::GEN_W-1:0]   r_gen;
    logic [lgs_pkg::ALIVE_W-1:0] r_alive;
    logic                        r_full;
    logic                        r_rd_inside;
    logic                        r_res_cell;
    logic                        r_o_valid;
    logic                        r_o_cell;
    logic [lgs_pkg::ALIVE_W-1:0] r_o_alive;
    logic [lgs_pkg::GEN_W-1:0]   r_o_gen;
    logic                        r_o_full;

    logic                        accept;
    logic                        on_grid;
    logic [AW-1:0]               req_addr;
    logic                        out_free;
    logic                        eng_start;

    // memory port
    lgs_pkg::t_mem_ctl mem_ctl;
    logic [AW:0]       mem_wr_addr;
    logic [AW:0]       mem_rd_addr;
    logic              mem_q;

    // step engine
    lgs_pkg::t_mem_ctl eng_ctl;
    logic [AW-1:0]     eng_rd_addr;
    logic [AW-1:0]     eng_wr_addr;
    logic              eng_done;
    logic [TW-1:0]     eng_total;

    logic [SW-1:0]               total_ext;
    logic [lgs_pkg::ALIVE_W-1:0] alive_nx;
    logic                        full_nx;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign on_grid    = (32'(i_row) < 32'(GRID_ROWS)) && (32'(i_col) < 32'(GRID_COLS));
    assign req_addr   = {ROW_AW'(i_row), COL_AW'(i_col)};
    assign out_free   = !r_o_valid || !i_out_stall;
    assign eng_start  = accept && (i_req_type == lgs_pkg::REQ_STEP);

    // statistics at the end of a step, live count saturating
    assign total_ext = SW'(eng_total);
    assign alive_nx  = (total_ext > SW'(lgs_pkg::ALIVE_MAX)) ?
                       lgs_pkg::ALIVE_W'(lgs_pkg::ALIVE_MAX) :
                       lgs_pkg::ALIVE_W'(eng_total);
    assign full_nx   = (eng_total == TW'(CELLS));

    // memory port arbitration
    always_comb begin
        mem_ctl     = '0;
        mem_wr_addr = '0;
        mem_rd_addr = '0;
        case (r_state)
            S_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = {1'b0, r_clr_addr};
            end
            S_IDLE: begin
                mem_ctl.wr_en   = accept && on_grid && (i_req_type == lgs_pkg::REQ_WRITE);
                mem_ctl.wr_data = i_cell_in;
                mem_ctl.rd_en   = accept && on_grid && (i_req_type == lgs_pkg::REQ_READ);
                mem_wr_addr     = {r_bank, req_addr};
                mem_rd_addr     = {r_bank, req_addr};
            end
            S_STEP: begin
                mem_ctl     = eng_ctl;
                mem_rd_addr = {r_bank, eng_rd_addr};
                mem_wr_addr = {~r_bank, eng_wr_addr};
            end
            default: begin
                mem_ctl = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == lgs_pkg::REQ_READ) begin
                        n_state = S_READ;
                    end else if (i_req_type == lgs_pkg::REQ_STEP) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_STEP: begin
                if (eng_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_bank     <= 1'b0;
            r_clr_addr <= '0;
            r_gen      <= '0;
            r_alive    <= '0;
            r_full     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // step finished: swap banks and publish statistics
            if ((r_state == S_STEP) && eng_done) begin
                r_bank  <= ~r_bank;
                r_gen   <= r_gen + 1'b1;
                r_alive <= alive_nx;
                r_full  <= full_nx;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result and output word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_inside <= on_grid;
            r_res_cell  <= 1'b0;
        end
        if (r_state == S_READ) begin
            r_res_cell <= r_rd_inside & mem_q;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_o_cell  <= r_res_cell;
            r_o_alive <= r_alive;
            r_o_gen   <= r_gen;
            r_o_full  <= r_full;
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_cell_out         = r_o_cell;
    assign o_alive_count      = r_o_alive;
    assign o_generation_count = r_o_gen;
    assign o_grid_full        = r_o_full;

    lgs_mem #(
        .AW(AW + 1)
    ) u_mem (
        .i_clk    (i_clk),
        .i_ctl    (mem_ctl),
        .i_wr_addr(mem_wr_addr),
        .i_rd_addr(mem_rd_addr),
        .o_rd_data(mem_q)
    );

    lgs_step_engine #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (eng_start),
        .i_rd_data(mem_q),
        .o_mem_ctl(eng_ctl),
        .o_rd_addr(eng_rd_addr),
        .o_wr_addr(eng_wr_addr),
        .o_done   (eng_done),
        .o_total  (eng_total)
    );

    // the engine only finishes while a step is in progress
    a_done_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (r_state == S_STEP))
        else $error("step engine finished outside a step");

    // a finished step advances the generation by exactly one
    a_gen_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP) && eng_done) |=> (r_gen == $past(r_gen) + 1'b1))
        else $error("generation count did not advance");

    // a pending result is held while the output word is stalled
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_o_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result lost while output stalled");

    // a full grid always reports the full live count
    a_full_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_alive == FULL_ALIVE))
        else $error("full flag disagrees with live count");

endmodule

// ===== tb/sv/life_generation_step_tb.sv =====
`timescale 1ns / 1ps

module life_generation_step_tb;

    // grid size under test
    localparam int ROWS = lgs_pkg::GRID_ROWS_DEF;
    localparam int COLS = lgs_pkg::GRID_COLS_DEF;

    // request code the block must ignore
    localparam logic [lgs_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // run shape
    localparam int DIR_ROWS    = 24;
    localparam int RAND_WORDS  = 112;
    localparam int STEP_BUDGET = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    // one output word as the block reports it
    typedef struct packed {
        logic                        cell_bit;
        logic [lgs_pkg::ALIVE_W-1:0] alive;
        logic [lgs_pkg::GEN_W-1:0]   gen;
        logic                        full;
    } t_life_word;

    // one directed row: request, plus a hand-typed answer where it is obvious
    typedef struct packed {
        logic [lgs_pkg::REQ_W-1:0]   req;
        logic [lgs_pkg::ROW_W-1:0]   row;
        logic [lgs_pkg::COL_W-1:0]   col;
        logic                        wr_bit;
        logic                        typed;
        logic                        exp_cell;
        logic [lgs_pkg::ALIVE_W-1:0] exp_alive;
        logic [lgs_pkg::GEN_W-1:0]   exp_gen;
        logic                        exp_full;
    } t_stim_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [lgs_pkg::REQ_W-1:0]   i_req_type = lgs_pkg::REQ_READ;
    logic [lgs_pkg::ROW_W-1:0]   i_row = '0;
    logic [lgs_pkg::COL_W-1:0]   i_col = '0;
    logic                        i_cell_in = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_cell_out;
    logic [lgs_pkg::ALIVE_W-1:0] o_alive_count;
    logic [lgs_pkg::GEN_W-1:0]   o_generation_count;
    logic                        o_grid_full;

    // shadow copy of the grid and its statistics
    bit                          life_cells [ROWS][COLS];
    logic [lgs_pkg::ALIVE_W-1:0] live_total = '0;
    logic [lgs_pkg::GEN_W-1:0]   gen_total = '0;
    bit                          full_now = 1'b0;

    // words still owed by the block, oldest first
    t_life_word         due_words [$];

    int err_cnt      = 0;
    int words_sent   = 0;
    int words_seen   = 0;
    int n_writes     = 0;
    int n_reads      = 0;
    int n_steps      = 0;
    int n_unused     = 0;
    int peak_alive   = 0;
    int burst_left   = 0;
    logic pressure_on = 1'b0;

    // directed rows: reset state, corners, ignored code, overwrite, a corner
    // birth, a blinker in mid-grid, lone corner cells dying
    t_stim_row dir_tbl [0:DIR_ROWS-1] = '{
        '{lgs_pkg::REQ_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 13'd0, 32'd0, 1'b0},
        '{REQ_UNUSED,         6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd0,  6'd63, 1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd63, 6'd0,  1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b1, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd0,  6'd1,  1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd1,  6'd0,  1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd31, 6'd30, 1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd31, 6'd31, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd31, 6'd31, 1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd31, 6'd32, 1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd1,  6'd1,  1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd30, 6'd31, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd0,  6'd63, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_STEP,  6'd63, 6'd63, 1'b1, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_STEP,  6'd21, 6'd42, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{REQ_UNUSED,         6'd17, 6'd42, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_WRITE, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0},
        '{lgs_pkg::REQ_READ,  6'd31, 6'd30, 1'b0, 1'b0, 1'b0, 13'd0, 32'd0, 1'b0}
    };

    life_generation_step #(
        .GRID_ROWS (ROWS),
        .GRID_COLS (COLS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_row              (i_row),
        .i_col              (i_col),
        .i_cell_in          (i_cell_in),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_cell_out         (o_cell_out),
        .o_alive_count      (o_alive_count),
        .o_generation_count (o_generation_count),
        .o_grid_full        (o_grid_full)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d words still owed", $time, due_words.size());
        $display("[life_generation_step] ERROR");
        $finish;
    end

    // one B3/S23 generation on the shadow grid, edges count as dead
    function automatic void life_advance();
        bit nxt [ROWS][COLS];
        int total;
        int nb;
        total = 0;
        gen_total = gen_total + 1'b1;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                nb = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
                            c + dc >= 0 && c + dc < COLS)
                            nb += life_cells[r+dr][c+dc];
                    end
                end
                nxt[r][c] = (nb == 3) || (life_cells[r][c] && nb == 2);
                total += nxt[r][c];
            end
        end
        life_cells = nxt;
        // full compares the true count, the reported count saturates
        full_now   = (total == ROWS * COLS);
        live_total = (total > lgs_pkg::ALIVE_MAX) ?
                     lgs_pkg::ALIVE_W'(lgs_pkg::ALIVE_MAX) : lgs_pkg::ALIVE_W'(total);
    endfunction

    // apply one request to the shadow state and return the word it owes
    function automatic t_life_word life_apply(logic [lgs_pkg::REQ_W-1:0] req,
                                              logic [lgs_pkg::ROW_W-1:0] r,
                                              logic [lgs_pkg::COL_W-1:0] c, logic v);
        t_life_word w;
        bit on_grid;
        on_grid    = (r < ROWS) && (c < COLS);
        w.cell_bit = 1'b0;
        case (req)
            lgs_pkg::REQ_WRITE: begin
                if (on_grid) life_cells[r][c] = v;
            end
            lgs_pkg::REQ_READ: begin
                if (on_grid) w.cell_bit = life_cells[r][c];
            end
            lgs_pkg::REQ_STEP: begin
                life_advance();
            end
            default: ;
        endcase
        w.alive = live_total;
        w.gen   = gen_total;
        w.full  = full_now;
        return w;
    endfunction

    // offer one word, hold it until taken, then book the owed answer
    task automatic send_word(input logic [lgs_pkg::REQ_W-1:0] req,
                             input logic [lgs_pkg::ROW_W-1:0] r,
                             input logic [lgs_pkg::COL_W-1:0] c, input logic v,
                             input logic typed, input t_life_word typed_word);
        t_life_word pred;
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_row      <= r;
        i_col      <= c;
        i_cell_in  <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = life_apply(req, r, c, v);
        due_words.push_back(typed ? typed_word : pred);
        words_sent++;
        case (req)
            lgs_pkg::REQ_WRITE: n_writes++;
            lgs_pkg::REQ_READ:  n_reads++;
            lgs_pkg::REQ_STEP:  n_steps++;
            default:            n_unused++;
        endcase
    endtask

    // sender bursts: after a burst runs out, usually drop valid for a random gap
    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [lgs_pkg::GEN_W-1:0] want,
                               input logic [lgs_pkg::GEN_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // output side: compare every taken word with the oldest owed one
    always @(posedge i_clk) begin
        t_life_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_seen++;
            if (o_alive_count > peak_alive) peak_alive = o_alive_count;
            if (due_words.size() == 0) begin
                $display("%0t: word with nothing owed, expected none got cell %0d gen %0d",
                         $time, o_cell_out, o_generation_count);
                err_cnt++;
            end else begin
                want = due_words.pop_front();
                check_field("cell_out", lgs_pkg::GEN_W'(want.cell_bit),
                            lgs_pkg::GEN_W'(o_cell_out));
                check_field("alive_count", lgs_pkg::GEN_W'(want.alive),
                            lgs_pkg::GEN_W'(o_alive_count));
                check_field("generation_count", want.gen, o_generation_count);
                check_field("grid_full", lgs_pkg::GEN_W'(want.full),
                            lgs_pkg::GEN_W'(o_grid_full));
            end
        end
    end

    // receiver: stall pattern that changes mode now and then, plus one long hold
    initial begin
        int mode;
        int phase_left;
        int hold_left;
        bit held;
        mode       = 0;
        phase_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_on && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                // long hold so the block fills and pushes back on its input
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 2);
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= 1'($urandom_range(0, 1));
                    default: i_out_stall <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // sender: reset, directed table, then random patterns and noise
    initial begin
        int steps_left;
        int base_r;
        int base_c;
        int n;
        logic [lgs_pkg::REQ_W-1:0] req;
        bit pressure_done;
        t_life_word typed_word;
        steps_left    = STEP_BUDGET;
        pressure_done = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the block clears its grid after reset with input stalled
        for (int k = 0; k < DIR_ROWS; k++) begin
            typed_word = '{dir_tbl[k].exp_cell, dir_tbl[k].exp_alive,
                           dir_tbl[k].exp_gen, dir_tbl[k].exp_full};
            send_word(dir_tbl[k].req, dir_tbl[k].row, dir_tbl[k].col, dir_tbl[k].wr_bit,
                      dir_tbl[k].typed, typed_word);
            pace();
        end

        while (words_sent < DIR_ROWS + RAND_WORDS) begin
            if (!pressure_done && words_sent >= DIR_ROWS + 30) begin
                // back-to-back writes against a stalled output
                pressure_done = 1'b1;
                pressure_on  <= 1'b1;
                for (int k = 0; k < 12; k++)
                    send_word(lgs_pkg::REQ_WRITE,
                              lgs_pkg::ROW_W'($urandom_range(0, ROWS - 1)),
                              lgs_pkg::COL_W'($urandom_range(0, COLS - 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
            end else if ($urandom_range(0, 3) != 0) begin
                // small random pattern, often on an edge or corner, then evolve and probe
                base_r = ($urandom_range(0, 3) == 0) ?
                         ($urandom_range(0, 1) ? ROWS - 4 : 0) : $urandom_range(0, ROWS - 4);
                base_c = ($urandom_range(0, 3) == 0) ?
                         ($urandom_range(0, 1) ? COLS - 4 : 0) : $urandom_range(0, COLS - 4);
                n = $urandom_range(4, 9);
                for (int k = 0; k < n; k++) begin
                    send_word(lgs_pkg::REQ_WRITE,
                              lgs_pkg::ROW_W'(base_r + $urandom_range(0, 3)),
                              lgs_pkg::COL_W'(base_c + $urandom_range(0, 3)),
                              ($urandom_range(0, 4) != 0), 1'b0, '0);
                    pace();
                end
                n = $urandom_range(1, 2);
                for (int k = 0; k < n && steps_left > 0; k++) begin
                    steps_left--;
                    send_word(lgs_pkg::REQ_STEP,
                              lgs_pkg::ROW_W'($urandom_range(0, ROWS - 1)),
                              lgs_pkg::COL_W'($urandom_range(0, COLS - 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                    pace();
                end
                n = $urandom_range(2, 4);
                for (int k = 0; k < n; k++) begin
                    send_word(lgs_pkg::REQ_READ,
                              lgs_pkg::ROW_W'(base_r + $urandom_range(0, 3)),
                              lgs_pkg::COL_W'(base_c + $urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                    pace();
                end
            end else begin
                // noise: any code, any address
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    req = lgs_pkg::REQ_W'($urandom_range(0, 3));
                    if (req == lgs_pkg::REQ_STEP) begin
                        if (steps_left > 0) steps_left--;
                        else req = lgs_pkg::REQ_READ;
                    end
                    send_word(req, lgs_pkg::ROW_W'($urandom_range(0, ROWS - 1)),
                              lgs_pkg::COL_W'($urandom_range(0, COLS - 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                    pace();
                end
            end
        end
        i_in_valid <= 1'b0;

        // drain, then give a late extra word time to show up
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d writes, %0d reads, %0d generation steps, %0d ignored codes",
                 n_writes, n_reads, n_steps, n_unused);
        $display("%0d words checked, peak live cells %0d", words_seen, peak_alive);
        if (err_cnt == 0) begin
            $display("[life_generation_step] OK");
        end else begin
            $display("[life_generation_step] ERROR");
        end
        $finish;
    end

endmodule

// ===== life_generation_step.f =====
rtl/lgs_pkg.sv
rtl/lgs_mem.sv
rtl/lgs_step_engine.sv
rtl/life_generation_step.sv
tb/sv/life_generation_step_tb.sv
